FILE: rtl/dpd_pkg.sv
// Package for the depth pixel deprojection block: widths, pipeline
// latencies, configuration register map and saturation helper.
// No dependencies.
package dpd_pkg;

  localparam int COORD_BITS    = 12;
  localparam int DEPTH_BITS    = 16;
  localparam int PIX_FRAC      = 8;
  localparam int CENTER_BITS   = COORD_BITS + PIX_FRAC;
  localparam int DIFF_BITS     = CENTER_BITS + 1;
  localparam int Q_BITS        = 32;
  localparam int FRAC_BITS     = 28;
  localparam int NORM_SHIFT    = 12;
  localparam int OUT_SHIFT     = 20;
  localparam int PROD_BITS     = 2 * Q_BITS;
  localparam int NPROD_BITS    = DIFF_BITS + Q_BITS + 1;
  localparam int SCALE_BITS    = Q_BITS + DEPTH_BITS + 1;
  localparam int T_BITS        = PROD_BITS - FRAC_BITS + 2;
  localparam int SAT_W         = 72;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam int NORM_LAT  = 3;
  localparam int RAD_LAT   = 8;
  localparam int PROJ_LAT  = 4;
  localparam int DEPTH_LAT = NORM_LAT + RAD_LAT;
  localparam int TOTAL_LAT = NORM_LAT + RAD_LAT + PROJ_LAT;

  typedef logic signed [Q_BITS-1:0]    q_t;
  typedef logic signed [PROD_BITS-1:0] qprod_t;
  typedef logic signed [T_BITS-1:0]    qterm_t;

  localparam q_t Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};
  localparam logic signed [SAT_W-1:0] ONE_Q = SAT_W'(2**FRAC_BITS);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_PRINCIPAL_X = 3'd0,
    REG_PRINCIPAL_Y = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_RADIAL_K1   = 3'd4,
    REG_RADIAL_K2   = 3'd5,
    REG_RADIAL_K3   = 3'd6,
    REG_TANGENTIAL  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CENTER_BITS-1:0] principal_x;
    logic [CENTER_BITS-1:0] principal_y;
    logic [Q_BITS-1:0]      inv_focal_x;
    logic [Q_BITS-1:0]      inv_focal_y;
    q_t                     k1;
    q_t                     k2;
    q_t                     k3;
    q_t                     p1;
    q_t                     p2;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    principal_x: CENTER_BITS'(82049),
    principal_y: CENTER_BITS'(60314),
    inv_focal_x: Q_BITS'(11185685),
    inv_focal_y: Q_BITS'(11185685),
    k1: '0,
    k2: '0,
    k3: '0,
    p1: '0,
    p2: '0
  };

  // clamp a wide signed value to the signed Q4.28 range
  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-Q_BITS:0] hi;
    hi = v[SAT_W-1:Q_BITS-1];
    if (&hi || ~|hi) begin
      return v[Q_BITS-1:0];
    end else if (v[SAT_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

FILE: rtl/dpd_norm.sv
// One axis of pixel normalization: center on the principal point, scale by
// the reciprocal focal length, saturate to Q4.28. Three register stages.
// Depends on dpd_pkg.
module dpd_norm import dpd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [COORD_BITS-1:0]  pix_i,
  input  logic [CENTER_BITS-1:0] center_i,
  input  logic [Q_BITS-1:0]      inv_i,
  output logic                   valid_o,
  output q_t                     norm_o
);

  logic [NORM_LAT-1:0]          vld_q;
  logic signed [DIFF_BITS-1:0]  diff_q, diff_d;
  logic signed [NPROD_BITS-1:0] prod_q, prod_d;
  q_t                           norm_q, norm_d;

  always_comb begin
    diff_d = $signed({1'b0, pix_i, PIX_FRAC'(0)}) - $signed({1'b0, center_i});
    prod_d = NPROD_BITS'(diff_q) * NPROD_BITS'($signed({1'b0, inv_i}));
    norm_d = sat_q(SAT_W'(prod_q >>> NORM_SHIFT));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NORM_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    prod_q <= prod_d;
    norm_q <= norm_d;
  end

  assign valid_o = vld_q[NORM_LAT-1];
  assign norm_o  = norm_q;

endmodule

FILE: rtl/dpd_radial.sv
// Radial distortion pipeline: r2, r2^2, r2^3 and the radial factor f, plus
// the x*y and r2+2x^2 / r2+2y^2 terms aligned with f. Eight register stages.
// Depends on dpd_pkg.
module dpd_radial import dpd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  q_t   x_i,
  input  q_t   y_i,
  input  cfg_t cfg_i,
  output logic valid_o,
  output q_t   f_o,
  output q_t   x_o,
  output q_t   y_o,
  output q_t   xy_o,
  output q_t   sx_o,
  output q_t   sy_o
);

  logic [RAD_LAT-1:0] vld_q;
  q_t     x_q [RAD_LAT];
  q_t     y_q [RAD_LAT];
  q_t     xy_q [RAD_LAT-1];
  q_t     sx_q [RAD_LAT-2];
  q_t     sy_q [RAD_LAT-2];
  qprod_t pxx_q, pyy_q, pxy_q;
  q_t     r2a_q, r2b_q, r2c_q, xx_q, yy_q;
  qprod_t pr4_q, pk1_q, pr6_q, pk2_q, pk3_q;
  q_t     r4_q, r6_q, f_q;
  qterm_t t1a_q, t1b_q, t12a_q, t12b_q;
  logic [PROD_BITS-1:0] sq_sum, sq_sh;
  q_t     r2_d;

  always_comb begin
    sq_sum = $unsigned(pxx_q) + $unsigned(pyy_q);
    sq_sh  = sq_sum >> FRAC_BITS;
    r2_d   = (|sq_sh[PROD_BITS-1:Q_BITS-1]) ? Q_MAX : q_t'(sq_sh[Q_BITS-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RAD_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= x_i;
    y_q[0] <= y_i;
    for (int i = 1; i < RAD_LAT; i++) begin
      x_q[i] <= x_q[i-1];
      y_q[i] <= y_q[i-1];
    end
    for (int i = 1; i < RAD_LAT - 1; i++) begin
      xy_q[i] <= xy_q[i-1];
    end
    for (int i = 1; i < RAD_LAT - 2; i++) begin
      sx_q[i] <= sx_q[i-1];
      sy_q[i] <= sy_q[i-1];
    end
    // R1
    pxx_q <= qprod_t'(x_i) * qprod_t'(x_i);
    pyy_q <= qprod_t'(y_i) * qprod_t'(y_i);
    pxy_q <= qprod_t'(x_i) * qprod_t'(y_i);
    // R2
    r2a_q   <= r2_d;
    xx_q    <= sat_q(SAT_W'(pxx_q >>> FRAC_BITS));
    yy_q    <= sat_q(SAT_W'(pyy_q >>> FRAC_BITS));
    xy_q[0] <= sat_q(SAT_W'(pxy_q >>> FRAC_BITS));
    // R3
    pr4_q   <= qprod_t'(r2a_q) * qprod_t'(r2a_q);
    pk1_q   <= qprod_t'(cfg_i.k1) * qprod_t'(r2a_q);
    r2b_q   <= r2a_q;
    sx_q[0] <= sat_q(SAT_W'(r2a_q) + (SAT_W'(xx_q) <<< 1));
    sy_q[0] <= sat_q(SAT_W'(r2a_q) + (SAT_W'(yy_q) <<< 1));
    // R4
    r4_q  <= sat_q(SAT_W'(pr4_q >>> FRAC_BITS));
    t1a_q <= qterm_t'(pk1_q >>> FRAC_BITS);
    r2c_q <= r2b_q;
    // R5
    pr6_q <= qprod_t'(r4_q) * qprod_t'(r2c_q);
    pk2_q <= qprod_t'(cfg_i.k2) * qprod_t'(r4_q);
    t1b_q <= t1a_q;
    // R6
    r6_q   <= sat_q(SAT_W'(pr6_q >>> FRAC_BITS));
    t12a_q <= t1b_q + qterm_t'(pk2_q >>> FRAC_BITS);
    // R7
    pk3_q  <= qprod_t'(cfg_i.k3) * qprod_t'(r6_q);
    t12b_q <= t12a_q;
    // R8
    f_q <= sat_q(ONE_Q + SAT_W'(t12b_q) + SAT_W'(pk3_q >>> FRAC_BITS));
  end

  assign valid_o = vld_q[RAD_LAT-1];
  assign f_o     = f_q;
  assign x_o     = x_q[RAD_LAT-1];
  assign y_o     = y_q[RAD_LAT-1];
  assign xy_o    = xy_q[RAD_LAT-2];
  assign sx_o    = sx_q[RAD_LAT-3];
  assign sy_o    = sy_q[RAD_LAT-3];

endmodule

FILE: rtl/dpd_proj.sv
// Tangential terms, undistorted x/y, depth scaling and output saturation.
// Four register stages ending in the registered result ports.
// Depends on dpd_pkg.
module dpd_proj import dpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  q_t                    f_i,
  input  q_t                    x_i,
  input  q_t                    y_i,
  input  q_t                    xy_i,
  input  q_t                    sx_i,
  input  q_t                    sy_i,
  input  logic [DEPTH_BITS-1:0] depth_i,
  input  cfg_t                  cfg_i,
  output logic                  valid_o,
  output q_t                    point_x_o,
  output q_t                    point_y_o,
  output logic [DEPTH_BITS-1:0] point_z_o
);

  logic [PROJ_LAT-1:0]          vld_q;
  logic [DEPTH_BITS-1:0]        dep_q [PROJ_LAT];
  qprod_t                       xf_q, yf_q, p1xy_q, p2sx_q, p2xy_q, p1sy_q;
  q_t                           ux_q, uy_q, px_q, py_q;
  logic signed [SCALE_BITS-1:0] mx_q, my_q;
  logic signed [SCALE_BITS-1:0] dep_s;

  assign dep_s = SCALE_BITS'($signed({1'b0, dep_q[1]}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PROJ_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dep_q[0] <= depth_i;
    for (int i = 1; i < PROJ_LAT; i++) begin
      dep_q[i] <= dep_q[i-1];
    end
    // P1
    xf_q   <= qprod_t'(x_i) * qprod_t'(f_i);
    yf_q   <= qprod_t'(y_i) * qprod_t'(f_i);
    p1xy_q <= qprod_t'(cfg_i.p1) * qprod_t'(xy_i);
    p2sx_q <= qprod_t'(cfg_i.p2) * qprod_t'(sx_i);
    p2xy_q <= qprod_t'(cfg_i.p2) * qprod_t'(xy_i);
    p1sy_q <= qprod_t'(cfg_i.p1) * qprod_t'(sy_i);
    // P2
    ux_q <= sat_q(SAT_W'(xf_q >>> FRAC_BITS) + (SAT_W'(p1xy_q >>> FRAC_BITS) <<< 1)
                  + SAT_W'(p2sx_q >>> FRAC_BITS));
    uy_q <= sat_q(SAT_W'(yf_q >>> FRAC_BITS) + (SAT_W'(p2xy_q >>> FRAC_BITS) <<< 1)
                  + SAT_W'(p1sy_q >>> FRAC_BITS));
    // P3
    mx_q <= SCALE_BITS'(ux_q) * dep_s;
    my_q <= SCALE_BITS'(uy_q) * dep_s;
    // P4
    px_q <= sat_q(SAT_W'(mx_q >>> OUT_SHIFT));
    py_q <= sat_q(SAT_W'(my_q >>> OUT_SHIFT));
  end

  assign valid_o   = vld_q[PROJ_LAT-1];
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = dep_q[PROJ_LAT-1];

endmodule

FILE: rtl/depth_pixel_deprojection.sv
// Depth pixel deprojection top level: configuration registers, depth delay
// line and the normalize / radial / projection pipeline.
// Depends on dpd_pkg, dpd_norm, dpd_radial and dpd_proj.
// A request taken at a clock edge passes the norm, radial and proj stages
// to the result ports, with done_o high for one cycle. Throughput: one
// pixel per cycle, set by the fully pipelined multipliers; busy_o stays
// low. Reset clears all valid bits and loads the default camera registers.
module depth_pixel_deprojection import dpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [COORD_BITS-1:0]    pixel_col_i,
  input  logic [COORD_BITS-1:0]    pixel_row_i,
  input  logic [DEPTH_BITS-1:0]    depth_raw_i,
  output logic                     done_o,
  output logic signed [Q_BITS-1:0] point_x_o,
  output logic signed [Q_BITS-1:0] point_y_o,
  output logic [DEPTH_BITS-1:0]    point_z_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  cfg_t                  cfg_q, cfg_d;
  logic                  req;
  logic                  nx_vld, ny_vld, rad_vld;
  q_t                    nx, ny;
  q_t                    f, rx, ry, rxy, rsx, rsy;
  logic [DEPTH_BITS-1:0] depth_q [DEPTH_LAT];

  assign busy_o = 1'b0;
  assign req    = start_i && !busy_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_PRINCIPAL_X: cfg_d.principal_x = cfg_wdata_i[CENTER_BITS-1:0];
        REG_PRINCIPAL_Y: cfg_d.principal_y = cfg_wdata_i[CENTER_BITS-1:0];
        REG_INV_FOCAL_X: cfg_d.inv_focal_x = cfg_wdata_i[Q_BITS-1:0];
        REG_INV_FOCAL_Y: cfg_d.inv_focal_y = cfg_wdata_i[Q_BITS-1:0];
        REG_RADIAL_K1:   cfg_d.k1 = q_t'(cfg_wdata_i[Q_BITS-1:0]);
        REG_RADIAL_K2:   cfg_d.k2 = q_t'(cfg_wdata_i[Q_BITS-1:0]);
        REG_RADIAL_K3:   cfg_d.k3 = q_t'(cfg_wdata_i[Q_BITS-1:0]);
        REG_TANGENTIAL: begin
          cfg_d.p1 = q_t'(cfg_wdata_i[Q_BITS-1:0]);
          cfg_d.p2 = q_t'(cfg_wdata_i[2*Q_BITS-1:Q_BITS]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    depth_q[0] <= depth_raw_i;
    for (int i = 1; i < DEPTH_LAT; i++) begin
      depth_q[i] <= depth_q[i-1];
    end
  end

  dpd_norm u_norm_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (req),
    .pix_i    (pixel_col_i),
    .center_i (cfg_q.principal_x),
    .inv_i    (cfg_q.inv_focal_x),
    .valid_o  (nx_vld),
    .norm_o   (nx)
  );

  dpd_norm u_norm_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (req),
    .pix_i    (pixel_row_i),
    .center_i (cfg_q.principal_y),
    .inv_i    (cfg_q.inv_focal_y),
    .valid_o  (ny_vld),
    .norm_o   (ny)
  );

  dpd_radial u_radial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nx_vld && ny_vld),
    .x_i     (nx),
    .y_i     (ny),
    .cfg_i   (cfg_q),
    .valid_o (rad_vld),
    .f_o     (f),
    .x_o     (rx),
    .y_o     (ry),
    .xy_o    (rxy),
    .sx_o    (rsx),
    .sy_o    (rsy)
  );

  dpd_proj u_proj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rad_vld),
    .f_i       (f),
    .x_i       (rx),
    .y_i       (ry),
    .xy_i      (rxy),
    .sx_i      (rsx),
    .sy_i      (rsy),
    .depth_i   (depth_q[DEPTH_LAT-1]),
    .cfg_i     (cfg_q),
    .valid_o   (done_o),
    .point_x_o (point_x_o),
    .point_y_o (point_y_o),
    .point_z_o (point_z_o)
  );

  a_norm_lanes_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nx_vld == ny_vld)
    else $error("normalization lanes out of step");

  a_request_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##TOTAL_LAT done_o)
    else $error("request did not produce a result");

  a_depth_passes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> point_z_o == $past(depth_raw_i, TOTAL_LAT))
    else $error("point_z does not match the request depth");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for depth_pixel_deprojection: drives pixel requests
// and camera register writes, predicts each 3-D point and compares it.
// Depends on dpd_pkg and the depth_pixel_deprojection RTL.
module tb_top;
  import dpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 72;

  typedef enum {CAM_TYPICAL, CAM_RANDOM, CAM_MAX, CAM_MIN} camera_e;

  typedef struct {
    logic signed [Q_BITS-1:0] x;
    logic signed [Q_BITS-1:0] y;
    logic [DEPTH_BITS-1:0]    z;
  } point_t;

  class pixel_deprojector;
    localparam longint SAT_HI = 64'sh7FFF_FFFF;
    localparam longint SAT_LO = -64'sh8000_0000;
    localparam longint UNITY  = 64'sh1000_0000;

    logic [19:0] principal_x;
    logic [19:0] principal_y;
    logic [31:0] inv_focal_x;
    logic [31:0] inv_focal_y;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic [63:0] tangential;
    point_t pending_points[$];
    int failures;

    function new();
      principal_x = 20'd82049;
      principal_y = 20'd60314;
      inv_focal_x = 32'd11185685;
      inv_focal_y = 32'd11185685;
      k1 = '0;
      k2 = '0;
      k3 = '0;
      tangential = '0;
      failures = 0;
    endfunction

    function longint clamp(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
    endfunction

    function longint normalize(logic [COORD_BITS-1:0] pix, logic [19:0] center,
                               logic [31:0] inv);
      longint d;
      d = longint'({pix, 8'b0}) - longint'(center);
      return clamp((d * longint'(inv)) >>> NORM_SHIFT);
    endfunction

    function logic signed [31:0] scale(longint u, logic [DEPTH_BITS-1:0] depth);
      longint p;
      p = clamp((u * longint'(depth)) >>> OUT_SHIFT);
      return p[31:0];
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] data);
      case (idx)
        REG_PRINCIPAL_X: principal_x = data[19:0];
        REG_PRINCIPAL_Y: principal_y = data[19:0];
        REG_INV_FOCAL_X: inv_focal_x = data[31:0];
        REG_INV_FOCAL_Y: inv_focal_y = data[31:0];
        REG_RADIAL_K1:   k1 = data[31:0];
        REG_RADIAL_K2:   k2 = data[31:0];
        REG_RADIAL_K3:   k3 = data[31:0];
        REG_TANGENTIAL:  tangential = data;
        default: ;
      endcase
    endfunction

    function point_t deproject(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                               logic [DEPTH_BITS-1:0] depth);
      point_t pt;
      logic [63:0] sq;
      longint x, y, p1, p2, r2, r4, r6, f, xy, xx, yy, sx, sy, ux, uy;
      p1 = longint'($signed(tangential[31:0]));
      p2 = longint'($signed(tangential[63:32]));
      x = normalize(col, principal_x, inv_focal_x);
      y = normalize(row, principal_y, inv_focal_y);
      sq = x * x;
      sq = sq + 64'(y * y);
      sq = sq >> FRAC_BITS;
      r2 = (sq > 64'h7FFF_FFFF) ? SAT_HI : longint'(sq);
      r4 = clamp(qmul(r2, r2));
      r6 = clamp(qmul(r4, r2));
      f = clamp(UNITY + qmul(longint'(k1), r2) + qmul(longint'(k2), r4)
                + qmul(longint'(k3), r6));
      xy = clamp(qmul(x, y));
      xx = clamp(qmul(x, x));
      yy = clamp(qmul(y, y));
      sx = clamp(r2 + 2 * xx);
      sy = clamp(r2 + 2 * yy);
      ux = clamp(qmul(x, f) + 2 * qmul(p1, xy) + qmul(p2, sx));
      uy = clamp(qmul(y, f) + 2 * qmul(p2, xy) + qmul(p1, sy));
      pt.x = scale(ux, depth);
      pt.y = scale(uy, depth);
      pt.z = depth;
      return pt;
    endfunction

    function void note_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                             logic [DEPTH_BITS-1:0] depth);
      pending_points.insert(pending_points.size(), deproject(col, row, depth));
    endfunction

    function void check_point(logic signed [Q_BITS-1:0] x, logic signed [Q_BITS-1:0] y,
                              logic [DEPTH_BITS-1:0] z);
      point_t want;
      if (pending_points.size() == 0) begin
        $error("point with no request outstanding: x %0d y %0d z %0d", x, y, z);
        failures++;
        return;
      end
      want = pending_points.pop_front();
      if (x !== want.x) begin
        $error("point_x: expected %0d, got %0d", want.x, x);
        failures++;
      end
      if (y !== want.y) begin
        $error("point_y: expected %0d, got %0d", want.y, y);
        failures++;
      end
      if (z !== want.z) begin
        $error("point_z: expected %0d, got %0d", want.z, z);
        failures++;
      end
    endfunction

    function int pending();
      return pending_points.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [COORD_BITS-1:0]    pixel_col_i;
  logic [COORD_BITS-1:0]    pixel_row_i;
  logic [DEPTH_BITS-1:0]    depth_raw_i;
  logic                     done_o;
  logic signed [Q_BITS-1:0] point_x_o;
  logic signed [Q_BITS-1:0] point_y_o;
  logic [DEPTH_BITS-1:0]    point_z_o;
  logic                     cfg_we_i;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  pixel_deprojector deproj = new();
  int cycle_count = 0;
  bit steady = 1'b0;

  depth_pixel_deprojection dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .depth_raw_i (depth_raw_i),
    .done_o      (done_o),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) deproj.check_point(point_x_o, point_y_o, point_z_o);
      if (cfg_we_i) deproj.write_reg(cfg_reg_e'(cfg_addr_i), cfg_wdata_i);
      if (start_i && !busy_o) deproj.note_pixel(pixel_col_i, pixel_row_i, depth_raw_i);
    end
  end

  task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                            input logic [COORD_BITS-1:0] row,
                            input logic [DEPTH_BITS-1:0] depth);
    while (!steady && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i     <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    depth_raw_i <= depth;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (deproj.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_camera(input camera_e mode);
    logic [63:0] vals [8];
    cfg_reg_e r;
    foreach (vals[i]) vals[i] = {$urandom, $urandom};
    case (mode)
      CAM_TYPICAL: begin
        vals[REG_PRINCIPAL_X][19:0] = 20'($urandom_range(0, 1279 * 256));
        vals[REG_PRINCIPAL_Y][19:0] = 20'($urandom_range(0, 959 * 256));
        vals[REG_INV_FOCAL_X][31:0] = $urandom_range(32'h0020_0000, 32'h0200_0000);
        vals[REG_INV_FOCAL_Y][31:0] = $urandom_range(32'h0020_0000, 32'h0200_0000);
        vals[REG_RADIAL_K1][31:0] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        vals[REG_RADIAL_K2][31:0] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        vals[REG_RADIAL_K3][31:0] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        vals[REG_TANGENTIAL] = {$urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                                $urandom_range(0, 32'h0200_0000) - 32'h0100_0000};
      end
      CAM_MAX: begin
        vals[REG_PRINCIPAL_X][19:0] = 20'hF_FFFF;
        vals[REG_PRINCIPAL_Y][19:0] = 20'hF_FFFF;
        vals[REG_INV_FOCAL_X][31:0] = 32'hFFFF_FFFF;
        vals[REG_INV_FOCAL_Y][31:0] = 32'hFFFF_FFFF;
        vals[REG_RADIAL_K1][31:0] = 32'h7FFF_FFFF;
        vals[REG_RADIAL_K2][31:0] = 32'h7FFF_FFFF;
        vals[REG_RADIAL_K3][31:0] = 32'h7FFF_FFFF;
        vals[REG_TANGENTIAL] = {2{32'h7FFF_FFFF}};
      end
      CAM_MIN: begin
        vals[REG_PRINCIPAL_X][19:0] = '0;
        vals[REG_PRINCIPAL_Y][19:0] = '0;
        vals[REG_INV_FOCAL_X][31:0] = '0;
        vals[REG_INV_FOCAL_Y][31:0] = '0;
        vals[REG_RADIAL_K1][31:0] = 32'h8000_0000;
        vals[REG_RADIAL_K2][31:0] = 32'h8000_0000;
        vals[REG_RADIAL_K3][31:0] = 32'h8000_0000;
        vals[REG_TANGENTIAL] = {2{32'h8000_0000}};
      end
      default: ;
    endcase
    r = r.first();
    repeat (r.num()) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= r;
      cfg_wdata_i <= vals[r];
      @(posedge clk_i);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_pixels(input int count, input bit typical);
    logic [COORD_BITS-1:0] col, row;
    logic [DEPTH_BITS-1:0] depth;
    repeat (count) begin
      col = COORD_BITS'((!typical || $urandom_range(3) == 0) ? $urandom
                                                              : $urandom_range(0, 1279));
      row = COORD_BITS'((!typical || $urandom_range(3) == 0) ? $urandom
                                                              : $urandom_range(0, 959));
      case ($urandom_range(7))
        0:       depth = '0;
        1:       depth = '1;
        2:       depth = DEPTH_BITS'($urandom_range(0, 255));
        default: depth = DEPTH_BITS'($urandom);
      endcase
      send_pixel(col, row, depth);
    end
  endtask

  initial begin
    camera_e plan [9];
    plan = '{CAM_TYPICAL, CAM_TYPICAL, CAM_RANDOM, CAM_TYPICAL, CAM_MAX,
             CAM_TYPICAL, CAM_MIN, CAM_RANDOM, CAM_TYPICAL};
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    pixel_col_i <= '0;
    pixel_row_i <= '0;
    depth_raw_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= REG_PRINCIPAL_X;
    cfg_wdata_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default camera after reset
    send_pixel(12'd0, 12'd0, 16'd0);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
    send_pixel(12'd320, 12'd235, 16'd1000);
    send_pixel(12'd0, 12'd4095, 16'hFFFF);
    send_pixel(12'd4095, 12'd0, 16'd1);
    send_pixel(12'd321, 12'd236, 16'hFFFF);
    send_pixel(12'd640, 12'd480, 16'h8000);
    drain();

    program_camera(CAM_TYPICAL);
    send_pixel(12'd0, 12'd0, 16'hFFFF);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
    send_pixel(12'd1279, 12'd0, 16'd4000);
    send_pixel(12'd0, 12'd959, 16'd250);
    send_pixel(12'hAAA, 12'h555, 16'hAAAA);
    send_pixel(12'h555, 12'hAAA, 16'h5555);
    drain();

    // saturation of normalized coordinates, distortion and output
    program_camera(CAM_MAX);
    send_pixel(12'd0, 12'd0, 16'hFFFF);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
    send_pixel(12'd4095, 12'd0, 16'd1);
    send_pixel(12'd2048, 12'd100, 16'd30000);
    drain();

    program_camera(CAM_MIN);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF);
    send_pixel(12'd0, 12'd0, 16'hFFFF);
    send_pixel(12'd17, 12'd4000, 16'd0);
    drain();

    foreach (plan[i]) begin
      program_camera(plan[i]);
      steady = (i == 1);
      random_pixels(PHASE_ITEMS, plan[i] == CAM_TYPICAL);
      drain();
    end

    repeat (TOTAL_LAT + 4) @(posedge clk_i);
    if (deproj.failures == 0 && deproj.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
